// File: rtl/gls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gls_pkg - shared types and constants of the grouped light mode selector
// Field widths, button codes, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package gls_pkg;

   localparam int MODE_W     = 4;
   localparam int RMODE_W    = 2;
   localparam int BTN_W      = 2;
   localparam int MASK_W     = 8;
   localparam int GCNT_W     = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   // modes at or above MASK_W carry no mask bit; EXT_W holds any mode index
   localparam int EXT_W      = 5;

   localparam logic [BTN_W-1:0] BTN_NONE  = 2'd0;
   localparam logic [BTN_W-1:0] BTN_SHORT = 2'd1;
   localparam logic [BTN_W-1:0] BTN_LONG  = 2'd2;
   localparam logic [BTN_W-1:0] BTN_ULTRA = 2'd3;

   localparam logic REQ_BUTTON = 1'b0;
   localparam logic REQ_REMOTE = 1'b1;

   localparam logic [RMODE_W-1:0] RMODE_OFF = 2'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE_OFF_MASK = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_COUNT   = 1'd1;

   localparam logic [MASK_W-1:0] MASK_RESET = 8'd204;
   localparam logic [GCNT_W-1:0] GCNT_RESET = 4'd2;

   typedef struct packed {
      logic               req_type;
      logic [BTN_W-1:0]   button_internal;
      logic [BTN_W-1:0]   button_vol_up;
      logic [BTN_W-1:0]   button_vol_down;
      logic [RMODE_W-1:0] remote_mode_in;
   } gls_item_type;

   typedef struct packed {
      logic force_sub;
      logic cmp_en;
   } gls_alu_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } gls_seq_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REDUCE,
      ST_ADV,
      ST_TEST,
      ST_FINISH
   } gls_state_type;

endpackage
`default_nettype wire

// File: rtl/gls_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gls_ifs - channel interfaces of the grouped light mode selector
// Request, response and register-write channels with valid/ready.
// ----------------------------------------------------------------------------
interface gls_req_if import gls_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [BTN_W-1:0]   button_internal;
   logic [BTN_W-1:0]   button_vol_up;
   logic [BTN_W-1:0]   button_vol_down;
   logic [RMODE_W-1:0] remote_mode_in;

   modport source (output valid, req_type, button_internal, button_vol_up,
                   button_vol_down, remote_mode_in, input ready);
   modport sink   (input valid, req_type, button_internal, button_vol_up,
                   button_vol_down, remote_mode_in, output ready);
endinterface

interface gls_rsp_if import gls_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode_index;
   logic [RMODE_W-1:0] remote_mode;
   logic               pair_request;

   modport source (output valid, mode_index, remote_mode, pair_request, input ready);
   modport sink   (input valid, mode_index, remote_mode, pair_request, output ready);
endinterface

interface gls_csr_if import gls_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/grouped_light_mode_selector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grouped_light_mode_selector - light mode selection from button events
// Button and remote transactions in, one result transaction out per input.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                          | accept
//  req_if   | in  | req_type, button_internal/vol_up/vol_down, remote | valid & ready
//  rsp_if   | out | mode_index, remote_mode, pair_request             | valid & ready
//  csr_if   | in  | index (0 mode_off_mask, 1 group_count), data      | valid & ready
//
//  Remote update: a transaction steps through check, finish and idle, and its
//  result is loaded into the output register in the finish step. A button
//  press adds the scan through the shared adder: repeated group-size
//  subtraction, then an advance step (the offset step or a group hop) before
//  each run of candidate tests.
//  Reset is synchronous: remote selected, remote off, mask 204, two groups.
//  req_if.ready is low while a transaction is in work; a stalled result holds
//  in the output register and the next transaction waits in its finish step.
// ----------------------------------------------------------------------------
module grouped_light_mode_selector import gls_pkg::*; #(
   parameter int NUM_MODES = 8
) (
   input  wire logic  clock,
   input  wire logic  reset,
   gls_req_if.sink    req_if,
   gls_rsp_if.source  rsp_if,
   gls_csr_if.sink    csr_if
);

   localparam int SEL_W = $clog2(NUM_MODES + 1);

   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic [GCNT_W-1:0]  gcnt_ff, gcnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [MODE_W-1:0]  rsp_mode_ff;
   logic [RMODE_W-1:0] rsp_rmode_ff;
   logic               rsp_pair_ff;

   gls_item_type       item;
   gls_seq_status_type status;
   logic [SEL_W-1:0]   sel;
   logic [RMODE_W-1:0] rmode;
   logic               pair;
   logic               start, slot_free, load;

   // gather the request fields into one item
   assign item = '{req_type:        req_if.req_type,
                   button_internal: req_if.button_internal,
                   button_vol_up:   req_if.button_vol_up,
                   button_vol_down: req_if.button_vol_down,
                   remote_mode_in:  req_if.remote_mode_in};

   assign req_if.ready = !status.busy;
   assign start        = req_if.valid && req_if.ready;

   // the output register is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign load      = status.done && slot_free;

   gls_seq #(.NUM_MODES(NUM_MODES)) u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .item          (item),
      .mode_off_mask (mask_ff),
      .group_count   (gcnt_ff),
      .slot_free     (slot_free),
      .status        (status),
      .sel           (sel),
      .rmode         (rmode),
      .pair          (pair)
   );

   // register writes; always ready
   assign csr_if.ready = 1'b1;

   always_comb begin
      mask_in = mask_ff;
      gcnt_in = gcnt_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_MODE_OFF_MASK: mask_in = csr_if.data[MASK_W-1:0];
            CSR_GROUP_COUNT:   gcnt_in = csr_if.data[GCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // hold the result until taken; a new load and a drain may coincide
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= MASK_RESET;
         gcnt_ff      <= GCNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         gcnt_ff      <= gcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload; mode index is masked to four bits for a sixteen-mode build
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_mode_ff  <= MODE_W'(sel);
         rsp_rmode_ff <= rmode;
         rsp_pair_ff  <= pair;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.mode_index   = rsp_mode_ff;
   assign rsp_if.remote_mode  = rsp_rmode_ff;
   assign rsp_if.pair_request = rsp_pair_ff;

`ifndef NO_ASSERTIONS
   // an accepted transaction keeps the input closed on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_if.ready)
      else $error("input still ready after accepting a transaction");

   // a pairing request only comes while the remote mode is off
   a_pair_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.pair_request) |-> (rsp_if.remote_mode == RMODE_OFF))
      else $error("pairing request with remote mode not off");

   // the selected mode never passes the remote index
   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (NUM_MODES < 16)) |-> (rsp_if.mode_index <= MODE_W'(NUM_MODES)))
      else $error("mode index out of range");

   // a result is loaded only when the sequencer has finished
   a_load_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(status.done))
      else $error("result loaded without a finished transaction");
`endif

endmodule
`default_nettype wire

// File: rtl/gls_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gls_alu - shared add / compare / subtract unit
// Computes a + b and takes c off when forced or when the sum reaches c.
// ----------------------------------------------------------------------------
module gls_alu import gls_pkg::*; #(
   parameter int W = 4
) (
   input  wire logic [W-1:0]    a,
   input  wire logic [W-1:0]    b,
   input  wire logic [W-1:0]    c,
   input  wire gls_alu_ctrl_type ctrl,
   output logic      [W-1:0]    res,
   output logic                 ge
);

   logic [W:0] sum;
   logic [W:0] diff;

   always_comb begin
      sum  = {1'b0, a} + {1'b0, b};
      ge   = sum >= {1'b0, c};
      diff = sum - {1'b0, c};
      // wrap by c on demand, or when the compare is enabled and the sum reaches c
      if (ctrl.force_sub || (ctrl.cmp_en && ge)) begin
         res = diff[W-1:0];
      end else begin
         res = sum[W-1:0];
      end
   end

endmodule
`default_nettype wire

// File: rtl/gls_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gls_seq - mode sequencer
// Holds the selected mode and remote mode, and scans candidates one per cycle.
// ----------------------------------------------------------------------------
module gls_seq import gls_pkg::*; #(
   parameter int NUM_MODES = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire gls_item_type                     item,
   input  wire logic [MASK_W-1:0]                mode_off_mask,
   input  wire logic [GCNT_W-1:0]                group_count,
   input  wire logic                             slot_free,
   output gls_seq_status_type                    status,
   output logic [$clog2(NUM_MODES + 1)-1:0]      sel,
   output logic [RMODE_W-1:0]                    rmode,
   output logic                                  pair
);

   localparam int SEL_W = $clog2(NUM_MODES + 1);
   localparam logic [SEL_W-1:0] REMOTE = SEL_W'(NUM_MODES);
   localparam logic [SEL_W-1:0] ZERO   = SEL_W'(0);
   localparam logic [SEL_W-1:0] ONE    = SEL_W'(1);
   localparam bit   G2_OK = (NUM_MODES % 2) == 0;
   localparam bit   G4_OK = (NUM_MODES >= 4) && ((NUM_MODES % 4) == 0);
   localparam bit   G8_OK = (NUM_MODES >= 8) && ((NUM_MODES % 8) == 0);
   localparam logic [SEL_W-1:0] MPG1 = SEL_W'(NUM_MODES);
   localparam logic [SEL_W-1:0] MPG2 = SEL_W'(NUM_MODES / 2);
   localparam logic [SEL_W-1:0] MPG4 = SEL_W'(NUM_MODES / 4);
   localparam logic [SEL_W-1:0] MPG8 = SEL_W'(NUM_MODES / 8);
   localparam logic [SEL_W-1:0] GRP2 = SEL_W'(2);
   localparam logic [SEL_W-1:0] GRP4 = SEL_W'(4);
   localparam logic [SEL_W-1:0] GRP8 = SEL_W'(8);

   gls_state_type      state_ff, state_in;
   logic [SEL_W-1:0]   sel_ff, sel_in;
   logic [RMODE_W-1:0] rmode_ff, rmode_in;
   logic               pair_ff, pair_in;
   gls_item_type       item_ff, item_in;
   logic [SEL_W-1:0]   cand_ff, cand_in;
   logic [SEL_W-1:0]   off_ff, off_in;
   logic [SEL_W-1:0]   cnt_ff, cnt_in;
   logic [SEL_W-1:0]   grp_ff, grp_in;
   logic               long_ff, long_in;
   logic               pend_ff, pend_in;

   logic [SEL_W-1:0]   mpg, geff, mpg_m1;
   logic [SEL_W-1:0]   alu_a, alu_b, alu_c, alu_res;
   gls_alu_ctrl_type   alu_ctrl;
   logic               alu_ge;
   logic [EXT_W-1:0]   cand_x;
   logic               cand_hit, last_off, last_cnt, last_grp;

   // check-step decode
   logic               is_remote, pair_now, off_now, short_p, long_p;
   logic               chk_scan, chk_long;
   logic [SEL_W-1:0]   chk_sel;

   // modes per group; a bad group count acts as a single group
   always_comb begin
      mpg  = MPG1;
      geff = ONE;
      case (group_count)
         4'd2: if (G2_OK) begin mpg = MPG2; geff = GRP2; end
         4'd4: if (G4_OK) begin mpg = MPG4; geff = GRP4; end
         4'd8: if (G8_OK) begin mpg = MPG8; geff = GRP8; end
         default: ;
      endcase
   end

   assign mpg_m1   = mpg - ONE;
   assign cand_x   = EXT_W'(cand_ff);
   assign cand_hit = (cand_x >= EXT_W'(MASK_W)) || !mode_off_mask[cand_x[2:0]];
   assign last_off = off_ff == mpg_m1;
   assign last_cnt = cnt_ff == mpg_m1;
   assign last_grp = !long_ff || (grp_ff == geff);

   always_comb begin
      is_remote = item_ff.req_type == REQ_REMOTE;
      pair_now  = (sel_ff == REMOTE) && (rmode_ff == RMODE_OFF) &&
                  (item_ff.button_internal == BTN_ULTRA);
      off_now   = (sel_ff != REMOTE) && ((item_ff.button_vol_down != BTN_NONE) ||
                  (item_ff.button_internal == BTN_ULTRA));
      short_p   = (item_ff.button_internal == BTN_SHORT) ||
                  (item_ff.button_vol_up == BTN_SHORT);
      long_p    = (item_ff.button_internal == BTN_LONG) ||
                  (item_ff.button_vol_up == BTN_LONG);
      chk_scan  = 1'b0;
      chk_long  = 1'b0;
      chk_sel   = off_now ? REMOTE : sel_ff;
      if (short_p && !off_now && (sel_ff != REMOTE)) begin
         chk_scan = 1'b1;
      end else if (short_p) begin
         // short press from remote lands on mode 0 unconditionally
         chk_sel  = ZERO;
         chk_scan = long_p;
         chk_long = long_p;
      end else if (long_p && !off_now && (sel_ff != REMOTE)) begin
         chk_scan = 1'b1;
         chk_long = 1'b1;
      end
   end

   gls_alu #(.W(SEL_W)) u_alu (
      .a    (alu_a),
      .b    (alu_b),
      .c    (alu_c),
      .ctrl (alu_ctrl),
      .res  (alu_res),
      .ge   (alu_ge)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_CHECK;
         ST_CHECK:  state_in = (!is_remote && chk_scan) ? ST_REDUCE : ST_FINISH;
         ST_REDUCE: if (!alu_ge) state_in = ST_ADV;
         ST_ADV:    state_in = ST_TEST;
         ST_TEST: begin
            if (cand_hit) begin
               state_in = (!long_ff && pend_ff) ? ST_REDUCE : ST_FINISH;
            end else if (last_cnt) begin
               state_in = last_grp ? ST_FINISH : ST_ADV;
            end
         end
         ST_FINISH: if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and shared-unit control
   always_comb begin
      sel_in   = sel_ff;
      rmode_in = rmode_ff;
      pair_in  = pair_ff;
      item_in  = item_ff;
      cand_in  = cand_ff;
      off_in   = off_ff;
      cnt_in   = cnt_ff;
      grp_in   = grp_ff;
      long_in  = long_ff;
      pend_in  = pend_ff;
      // default: step to the next candidate inside the group
      alu_a    = cand_ff;
      alu_b    = ONE;
      alu_c    = mpg;
      alu_ctrl = '{force_sub: last_off, cmp_en: 1'b0};
      unique case (state_ff)
         ST_IDLE: if (start) item_in = item;
         ST_CHECK: begin
            if (is_remote) begin
               rmode_in = item_ff.remote_mode_in;
               pair_in  = 1'b0;
            end else begin
               pair_in  = pair_now;
               sel_in   = chk_sel;
               if (off_now) rmode_in = RMODE_OFF;
               cand_in  = chk_sel;
               off_in   = chk_sel;
               long_in  = chk_long;
               pend_in  = long_p;
               grp_in   = ZERO;
            end
         end
         ST_REDUCE: begin
            // offset within group by repeated subtraction
            alu_a    = off_ff;
            alu_b    = ZERO;
            alu_c    = mpg;
            alu_ctrl = '{force_sub: 1'b0, cmp_en: 1'b1};
            if (alu_ge) off_in = alu_res;
         end
         ST_ADV: begin
            cnt_in = ZERO;
            if (long_ff) begin
               // hop to the same offset in the next group, wrapping at the top
               alu_b    = mpg;
               alu_c    = REMOTE;
               alu_ctrl = '{force_sub: 1'b0, cmp_en: 1'b1};
               grp_in   = grp_ff + ONE;
            end else begin
               off_in = last_off ? ZERO : off_ff + ONE;
            end
            cand_in = alu_res;
         end
         ST_TEST: begin
            if (cand_hit) begin
               sel_in = cand_ff;
               if (!long_ff && pend_ff) begin
                  long_in = 1'b1;
                  off_in  = cand_ff;
                  grp_in  = ZERO;
               end
            end else begin
               cand_in = alu_res;
               off_in  = last_off ? ZERO : off_ff + ONE;
               cnt_in  = cnt_ff + ONE;
               if (last_cnt && last_grp) begin
                  // nothing enabled: drop to off
                  sel_in   = REMOTE;
                  rmode_in = RMODE_OFF;
               end
            end
         end
         ST_FINISH: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= REMOTE;
         rmode_ff <= RMODE_OFF;
         long_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         rmode_ff <= rmode_in;
         long_ff  <= long_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
      item_ff <= item_in;
      cand_ff <= cand_in;
      off_ff  <= off_in;
      cnt_ff  <= cnt_in;
      grp_ff  <= grp_in;
   end

   assign status = '{busy: state_ff != ST_IDLE, done: state_ff == ST_FINISH};
   assign sel    = sel_ff;
   assign rmode  = rmode_ff;
   assign pair   = pair_ff;

endmodule
`default_nettype wire

// File: tb/grouped_light_mode_selector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_light_mode_selector_test - self-checking bench for the mode selector
// Walks a table of directed button and remote transactions, then runs random
// phases under changing register settings. A behavioral predictor computes
// each expected result at acceptance, and a monitor checks the responses in
// order. Both channel sides idle at random, and one phase stalls the response
// side long enough for the block to back up its request side.
// ----------------------------------------------------------------------------
module grouped_light_mode_selector_test import gls_pkg::*; ();

   localparam int NUM_MODES       = 8;
   localparam int REMOTE_IDX      = NUM_MODES;   // selected index meaning remote
   localparam int SETTLE_CYCLES   = 3 * NUM_MODES + 16;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_COUNT     = 8;
   localparam int PHASE_ITEMS     = 194;
   localparam int CYCLE_LIMIT     = 400000;

   localparam logic [MODE_W-1:0]  REMOTE_SEL = MODE_W'(REMOTE_IDX);
   localparam logic [MODE_W-1:0]  FIRST_SEL  = MODE_W'(0);

   localparam logic [RMODE_W-1:0] RMODE_DIM  = 2'd1;
   localparam logic [RMODE_W-1:0] RMODE_LOW  = 2'd2;
   localparam logic [RMODE_W-1:0] RMODE_FULL = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]  mode_index;
      logic [RMODE_W-1:0] remote_mode;
      logic               pair_request;
   } light_result_type;

   typedef struct {
      bit                    is_csr;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_data;
      gls_item_type          req;
      bit                    typed;
      light_result_type      want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gls_req_if req_ch ();
   gls_rsp_if rsp_ch ();
   gls_csr_if csr_ch ();

   grouped_light_mode_selector #(.NUM_MODES(NUM_MODES)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the selector: registers and state as the block should hold them
   logic [MASK_W-1:0]  cfg_off_mask    = MASK_RESET;
   logic [GCNT_W-1:0]  cfg_group_count = GCNT_RESET;
   int unsigned        cur_mode        = REMOTE_IDX;
   logic [RMODE_W-1:0] cur_remote      = RMODE_OFF;

   light_result_type expected_results[$];
   stim_row_type     directed_rows[$];
   int            error_count   = 0;
   int            cycle_count   = 0;
   bit            no_gaps       = 1'b0;   // run both sides back to back
   bit            hold_off_req  = 1'b0;   // ask the receiver for one long stall

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Invalid group counts (zero, not a power of two, not a divisor) act as one group.
   function automatic int unsigned modes_in_group();
      int unsigned g;
      g = 32'(cfg_group_count);
      if (g == 0 || (g & (g - 1)) != 0 || g > NUM_MODES || (NUM_MODES % g) != 0)
         g = 1;
      return NUM_MODES / g;
   endfunction

   // Modes beyond the mask width have no disable bit.
   function automatic bit mode_on(int unsigned m);
      if (m >= MASK_W)
         return 1'b1;
      return !cfg_off_mask[m];
   endfunction

   // Scan the group of start from its offset plus first_k, wrapping inside the group.
   function automatic bit find_in_group(int unsigned start, int unsigned mpg,
                                        int unsigned first_k, output int unsigned hit_mode);
      int unsigned base;
      int unsigned off;
      int unsigned cand;
      base     = start - (start % mpg);
      off      = start % mpg;
      hit_mode = 0;
      for (int unsigned k = first_k; k < first_k + mpg; k++) begin
         cand = base + ((off + k) % mpg);
         if (mode_on(cand)) begin
            hit_mode = cand;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void go_dark();
      cur_mode   = REMOTE_IDX;
      cur_remote = RMODE_OFF;
   endfunction

   // Advance the shadow state by one request and return the response it yields.
   function automatic light_result_type next_light(gls_item_type it);
      int unsigned      mpg;
      int unsigned      start;
      int unsigned      found;
      bit               pair;
      bit               hit;
      light_result_type res;
      pair = 1'b0;
      if (it.req_type == REQ_REMOTE) begin
         cur_remote = it.remote_mode_in;
      end else begin
         mpg = modes_in_group();
         // pairing looks at the state before anything else in this press
         if (cur_mode == REMOTE_IDX && cur_remote == RMODE_OFF &&
             it.button_internal == BTN_ULTRA)
            pair = 1'b1;
         if (cur_mode != REMOTE_IDX &&
             (it.button_vol_down != BTN_NONE || it.button_internal == BTN_ULTRA))
            go_dark();
         if (it.button_internal == BTN_SHORT || it.button_vol_up == BTN_SHORT) begin
            if (cur_mode == REMOTE_IDX)
               cur_mode = 0;               // taken even when mode 0 is disabled
            else if (find_in_group(cur_mode, mpg, 1, found))
               cur_mode = found;
            else
               go_dark();
         end
         if (cur_mode != REMOTE_IDX &&
             (it.button_internal == BTN_LONG || it.button_vol_up == BTN_LONG)) begin
            hit = 1'b0;
            for (int unsigned g = 1; g <= NUM_MODES / mpg && !hit; g++) begin
               start = (cur_mode + g * mpg) % NUM_MODES;
               hit   = find_in_group(start, mpg, 0, found);
            end
            if (hit)
               cur_mode = found;
            else
               go_dark();
         end
      end
      res.mode_index   = cur_mode[MODE_W-1:0];
      res.remote_mode  = cur_remote;
      res.pair_request = pair;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic int draw_wait();
      if (no_gaps)
         return 0;
      return $urandom_range(0, 9);
   endfunction

   function automatic void add_req(logic rt, logic [BTN_W-1:0] bi, logic [BTN_W-1:0] vu,
                                   logic [BTN_W-1:0] vd, logic [RMODE_W-1:0] rm,
                                   bit typed = 1'b0, logic [MODE_W-1:0] mi = '0,
                                   logic [RMODE_W-1:0] ro = '0, logic pr = 1'b0);
      stim_row_type row;
      row.is_csr                  = 1'b0;
      row.reg_idx                 = '0;
      row.reg_data                = '0;
      row.req.req_type            = rt;
      row.req.button_internal     = bi;
      row.req.button_vol_up       = vu;
      row.req.button_vol_down     = vd;
      row.req.remote_mode_in      = rm;
      row.typed                   = typed;
      row.want.mode_index         = mi;
      row.want.remote_mode        = ro;
      row.want.pair_request       = pr;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      stim_row_type row;
      row          = '{default: '0};
      row.is_csr   = 1'b1;
      row.reg_idx  = idx;
      row.reg_data = value;
      directed_rows.push_back(row);
   endfunction

   // Mostly well-formed presses, some remote updates, some fully random noise.
   function automatic gls_item_type random_request();
      gls_item_type it;
      int           pick;
      it.req_type        = REQ_BUTTON;
      it.button_internal = BTN_NONE;
      it.button_vol_up   = BTN_NONE;
      it.button_vol_down = BTN_NONE;
      it.remote_mode_in  = RMODE_W'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         // remote update; button fields are don't-care and get random junk
         it.req_type        = REQ_REMOTE;
         it.button_internal = BTN_W'($urandom_range(0, 3));
         it.button_vol_up   = BTN_W'($urandom_range(0, 3));
         it.button_vol_down = BTN_W'($urandom_range(0, 3));
      end else if (pick < 22) begin
         it.button_internal = BTN_W'($urandom_range(0, 3));
         it.button_vol_up   = BTN_W'($urandom_range(0, 3));
         it.button_vol_down = BTN_W'($urandom_range(0, 3));
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: it.button_internal = BTN_SHORT;
            4:          it.button_vol_up   = BTN_SHORT;
            5, 6:       it.button_internal = BTN_LONG;
            7:          it.button_vol_up   = BTN_LONG;
            8:          it.button_internal = BTN_ULTRA;
            default:    it.button_vol_down = BTN_W'($urandom_range(1, 3));
         endcase
         if ($urandom_range(0, 7) == 0)
            it.button_vol_up = BTN_W'($urandom_range(0, 3));
      end
      return it;
   endfunction

   // Offer one request after a random gap; predict its response once it is accepted.
   task automatic send_request(input gls_item_type it, input bit typed,
                               input light_result_type given);
      int               gap;
      light_result_type guess;
      gap = draw_wait();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.req_type        <= it.req_type;
      req_ch.button_internal <= it.button_internal;
      req_ch.button_vol_up   <= it.button_vol_up;
      req_ch.button_vol_down <= it.button_vol_down;
      req_ch.remote_mode_in  <= it.remote_mode_in;
      do @(posedge clock); while (!req_ch.ready);
      // the predictor always runs so its state tracks typed rows too
      guess = next_light(it);
      expected_results.push_back(typed ? given : guess);
   endtask

   // Drop valid, wait for every response, then give the scan time to wind down.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_MODE_OFF_MASK)
         cfg_off_mask = value;
      else
         cfg_group_count = value[GCNT_W-1:0];
      // let valid fall before the task returns, so a following write starts on a fresh edge
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stalls, plus one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin : rsp_receiver
      int stall;
      rsp_ch.ready <= 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            stall        = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
         end else begin
            stall = draw_wait();
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare each accepted response with the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      light_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            $error("response with nothing outstanding: %s %0d %s %0d %s %0d",
                   "mode_index", rsp_ch.mode_index, "remote_mode", rsp_ch.remote_mode,
                   "pair_request", rsp_ch.pair_request);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_ch.mode_index !== want.mode_index) begin
               $error("mode_index: expected %0d, got %0d", want.mode_index, rsp_ch.mode_index);
               error_count++;
            end
            if (rsp_ch.remote_mode !== want.remote_mode) begin
               $error("remote_mode: expected %0d, got %0d", want.remote_mode, rsp_ch.remote_mode);
               error_count++;
            end
            if (rsp_ch.pair_request !== want.pair_request) begin
               $error("pair_request: expected %0d, got %0d",
                      want.pair_request, rsp_ch.pair_request);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[grouped_light_mode_selector] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_seq
      logic [MASK_W-1:0]     phase_mask  [PHASE_COUNT];
      logic [CSR_DATA_W-1:0] phase_groups[PHASE_COUNT];
      light_result_type      unused;

      // Hold every input at a known value from time zero
      req_ch.valid           <= 1'b0;
      req_ch.req_type        <= REQ_BUTTON;
      req_ch.button_internal <= BTN_NONE;
      req_ch.button_vol_up   <= BTN_NONE;
      req_ch.button_vol_down <= BTN_NONE;
      req_ch.remote_mode_in  <= RMODE_OFF;
      csr_ch.valid           <= 1'b0;
      csr_ch.index           <= CSR_MODE_OFF_MASK;
      csr_ch.data            <= '0;
      unused                 = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table. Reset state: remote selected, remote off, modes 2, 3, 6, 7
      // disabled, two groups of four. Typed rows are the obvious ones.
      add_req(REQ_BUTTON, BTN_NONE,  BTN_NONE,  BTN_NONE,  RMODE_OFF,
              1'b1, REMOTE_SEL, RMODE_OFF, 1'b0);
      // ultra-long press while off: pairing request, nothing else moves
      add_req(REQ_BUTTON, BTN_ULTRA, BTN_NONE,  BTN_NONE,  RMODE_OFF,
              1'b1, REMOTE_SEL, RMODE_OFF, 1'b1);
      // remote update ignores all-ones button fields
      add_req(REQ_REMOTE, BTN_ULTRA, BTN_ULTRA, BTN_ULTRA, RMODE_FULL,
              1'b1, REMOTE_SEL, RMODE_FULL, 1'b0);
      // remote on: ultra-long press neither pairs nor turns off
      add_req(REQ_BUTTON, BTN_ULTRA, BTN_NONE,  BTN_NONE,  RMODE_OFF,
              1'b1, REMOTE_SEL, RMODE_FULL, 1'b0);
      // volume down is ignored in remote; the short press then selects mode 0
      add_req(REQ_BUTTON, BTN_SHORT, BTN_NONE,  BTN_LONG,  RMODE_OFF,
              1'b1, FIRST_SEL, RMODE_FULL, 1'b0);
      add_req(REQ_BUTTON, BTN_SHORT, BTN_NONE,  BTN_NONE,  RMODE_OFF);
      add_req(REQ_BUTTON, BTN_NONE,  BTN_SHORT, BTN_NONE,  RMODE_DIM);
      add_req(REQ_BUTTON, BTN_LONG,  BTN_NONE,  BTN_NONE,  RMODE_OFF);
      add_req(REQ_BUTTON, BTN_NONE,  BTN_LONG,  BTN_NONE,  RMODE_LOW);
      // volume up code 3 does nothing
      add_req(REQ_BUTTON, BTN_NONE,  BTN_ULTRA, BTN_NONE,  RMODE_OFF);
      add_req(REQ_BUTTON, BTN_SHORT, BTN_LONG,  BTN_NONE,  RMODE_OFF);
      // volume down code 3 still turns off
      add_req(REQ_BUTTON, BTN_NONE,  BTN_NONE,  BTN_ULTRA, RMODE_OFF,
              1'b1, REMOTE_SEL, RMODE_OFF, 1'b0);
      add_req(REQ_BUTTON, BTN_SHORT, BTN_NONE,  BTN_NONE,  RMODE_OFF,
              1'b1, FIRST_SEL, RMODE_OFF, 1'b0);
      add_req(REQ_BUTTON, BTN_NONE,  BTN_NONE,  BTN_SHORT, RMODE_OFF,
              1'b1, REMOTE_SEL, RMODE_OFF, 1'b0);
      add_req(REQ_BUTTON, BTN_NONE,  BTN_SHORT, BTN_NONE,  RMODE_OFF,
              1'b1, FIRST_SEL, RMODE_OFF, 1'b0);
      // ultra-long in a button mode turns off without pairing
      add_req(REQ_BUTTON, BTN_ULTRA, BTN_NONE,  BTN_NONE,  RMODE_OFF,
              1'b1, REMOTE_SEL, RMODE_OFF, 1'b0);
      add_req(REQ_REMOTE, BTN_NONE,  BTN_NONE,  BTN_NONE,  RMODE_LOW,
              1'b1, REMOTE_SEL, RMODE_LOW, 1'b0);
      // first group fully disabled: mode 0 is still taken from remote,
      // the next short press finds nothing and goes off
      add_csr(CSR_MODE_OFF_MASK, 8'h0F);
      add_req(REQ_BUTTON, BTN_SHORT, BTN_NONE,  BTN_NONE,  RMODE_OFF,
              1'b1, FIRST_SEL, RMODE_LOW, 1'b0);
      add_req(REQ_BUTTON, BTN_SHORT, BTN_NONE,  BTN_NONE,  RMODE_OFF,
              1'b1, REMOTE_SEL, RMODE_OFF, 1'b0);
      // every mode disabled: a long press finds nothing anywhere
      add_csr(CSR_MODE_OFF_MASK, 8'hFF);
      add_req(REQ_BUTTON, BTN_NONE,  BTN_SHORT, BTN_NONE,  RMODE_OFF,
              1'b1, FIRST_SEL, RMODE_OFF, 1'b0);
      add_req(REQ_BUTTON, BTN_LONG,  BTN_NONE,  BTN_NONE,  RMODE_OFF,
              1'b1, REMOTE_SEL, RMODE_OFF, 1'b0);
      // group count 3 is invalid and acts as one group of eight
      add_csr(CSR_GROUP_COUNT, 8'h03);
      add_csr(CSR_MODE_OFF_MASK, 8'h7F);
      add_req(REQ_BUTTON, BTN_SHORT, BTN_NONE,  BTN_NONE,  RMODE_OFF,
              1'b1, FIRST_SEL, RMODE_OFF, 1'b0);
      add_req(REQ_BUTTON, BTN_SHORT, BTN_NONE,  BTN_NONE,  RMODE_OFF);
      // eight groups of one
      add_csr(CSR_GROUP_COUNT, 8'h08);
      add_csr(CSR_MODE_OFF_MASK, 8'h55);
      add_req(REQ_BUTTON, BTN_LONG,  BTN_NONE,  BTN_NONE,  RMODE_OFF);
      add_req(REQ_BUTTON, BTN_NONE,  BTN_SHORT, BTN_NONE,  RMODE_OFF);
      // zero groups, then four groups with junk in the upper data bits
      add_csr(CSR_GROUP_COUNT, 8'h00);
      add_req(REQ_BUTTON, BTN_LONG,  BTN_NONE,  BTN_SHORT, RMODE_OFF);
      add_csr(CSR_GROUP_COUNT, 8'hF4);
      add_req(REQ_BUTTON, BTN_SHORT, BTN_NONE,  BTN_NONE,  RMODE_OFF);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            wait_drained();
            write_register(directed_rows[i].reg_idx, directed_rows[i].reg_data);
         end else begin
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // Random phases: extremes of the mask and group count among them
      phase_mask   = '{8'h00, 8'hFF, 8'h00, 8'hCC, 8'h00, 8'h7E, 8'h00, 8'h01};
      phase_groups = '{8'h01, 8'h04, 8'h08, 8'h02, 8'h00, 8'h0F, 8'h00, 8'h04};
      phase_mask[2]   = MASK_W'($urandom_range(0, 255));
      phase_mask[4]   = MASK_W'($urandom_range(0, 255));
      phase_mask[6]   = MASK_W'($urandom_range(0, 255));
      phase_groups[6] = CSR_DATA_W'($urandom_range(0, 255));

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_drained();
         write_register(CSR_MODE_OFF_MASK, phase_mask[p]);
         // random upper nibble: the block keeps only the low four bits
         write_register(CSR_GROUP_COUNT,
                        {4'($urandom_range(0, 15)), phase_groups[p][GCNT_W-1:0]});
         no_gaps = (p == 3);
         // stall responses for a long stretch while requests keep coming
         if (p == 5)
            hold_off_req = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_request(random_request(), 1'b0, unused);
      end

      wait_drained();
      if (error_count == 0)
         $display("[grouped_light_mode_selector] OK");
      else
         $display("[grouped_light_mode_selector] ERROR");
      $finish;
   end

endmodule

// File: filelist.f
rtl/gls_pkg.sv
rtl/gls_ifs.sv
rtl/gls_alu.sv
rtl/gls_seq.sv
rtl/grouped_light_mode_selector.sv
tb/grouped_light_mode_selector_test.sv
